FILE: hdl/swftm_pkg.sv
package swftm_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_BUDGET     = 2'd2;

    // Reset values of the registers and the budget
    localparam logic        RST_ADAPTIVE_ENABLE = 1'b1;
    localparam logic [31:0] RST_SLOW_THRESHOLD  = 32'd16000000;
    localparam logic [31:0] RST_FULL_BUDGET     = 32'd100000;

    typedef struct packed {
        logic [63:0] start_stamp;
        logic [63:0] end_stamp;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] mean_time;
        logic [31:0] peak_time;
        logic [31:0] budget_now;
        logic [31:0] frames_seen;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/swftm_ram.sv
module swftm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 120
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sliding_window_frame_time_monitor_top.sv
// One frame is in work at a time, and a new one is taken only back in idle. The peak scan
// over the ring RAM's single read port sets the pace, with the mean formed alongside it by a
// reciprocal multiply in four partial products.
// Reset: asynchronous, active low; a clearing pass then zeroes the ring, with in_ready low
// meanwhile. Configuration writes are taken at all times.
// Input ready is high in idle, also while an earlier result waits in the output register.
module sliding_window_frame_time_monitor_top
    import swftm_pkg::*;
#(
    parameter int WINDOW_LEN = 120
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_beat,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int AW    = $clog2(WINDOW_LEN);
    localparam int CW    = $clog2(WINDOW_LEN + 1);
    localparam int TOT_W = 32 + $clog2(WINDOW_LEN);
    localparam int SH    = TOT_W + $clog2(WINDOW_LEN);
    localparam int HX    = (TOT_W + 1) / 2;
    localparam int HM    = (TOT_W + 2) / 2;
    localparam int XW    = 2 * HX;
    localparam int MW    = 2 * HM;
    localparam int PPW   = HX + HM;
    localparam int PW    = XW + MW;

    // Rounded-up reciprocal of the window length, exact for every running sum
    localparam logic [63:0]   RECIP_FULL =
        ((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];

    state_t state_reg, state_next;

    logic              adaptive_reg;
    logic [31:0]       threshold_reg;
    logic [31:0]       full_budget_reg;

    logic [AW-1:0]     pos_reg, pos_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [31:0]       budget_reg, budget_next;
    logic [31:0]       frames_reg, frames_next;
    logic [31:0]       dur_reg, dur_next;
    logic [31:0]       peak_reg, peak_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [2:0]        mstep_reg, mstep_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_beat_reg, out_beat_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;

    logic [63:0]       diff;
    logic [XW-1:0]     mul_x;
    logic [HX-1:0]     mul_a;
    logic [HM-1:0]     mul_b;
    logic [PPW-1:0]    mul_p;
    logic [PW-1:0]     mul_term;
    logic              scan_done;
    logic              mul_done;
    logic [31:0]       mean_val;

    swftm_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Duration modulo 2^64, saturated to 32 bits
    assign diff = in_beat.end_stamp - in_beat.start_stamp;

    // One partial product of the running sum times the reciprocal
    assign mul_x    = XW'(total_reg);
    assign mul_a    = mstep_reg[0] ? mul_x[XW-1:HX] : mul_x[HX-1:0];
    assign mul_b    = mstep_reg[1] ? RECIP[MW-1:HM] : RECIP[HM-1:0];
    assign mul_p    = PPW'(mul_a) * PPW'(mul_b);
    assign mul_term = PW'(mul_p) << ((mstep_reg[0] ? HX : 0) + (mstep_reg[1] ? HM : 0));

    assign scan_done = (cnt_reg == CW'(WINDOW_LEN)) && !rd_valid_reg;
    assign mul_done  = mstep_reg[2];
    assign mean_val  = prod_reg[SH+31:SH];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adaptive_reg    <= RST_ADAPTIVE_ENABLE;
            threshold_reg   <= RST_SLOW_THRESHOLD;
            full_budget_reg <= RST_FULL_BUDGET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ADAPTIVE_ENABLE: adaptive_reg    <= cfg_data[0];
                CFG_SLOW_THRESHOLD:  threshold_reg   <= cfg_data;
                CFG_FULL_BUDGET:     full_budget_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            total_reg     <= '0;
            budget_reg    <= RST_FULL_BUDGET;
            frames_reg    <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            mstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            budget_reg    <= budget_next;
            frames_reg    <= frames_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            mstep_reg     <= mstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dur_reg      <= dur_next;
        peak_reg     <= peak_next;
        prod_reg     <= prod_next;
        out_beat_reg <= out_beat_next;
    end

    // Sequencer: next state, datapath and RAM control
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        budget_next    = budget_reg;
        frames_next    = frames_reg;
        cnt_next       = cnt_reg;
        rd_valid_next  = 1'b0;
        mstep_next     = mstep_reg;
        out_valid_next = out_valid_reg;
        dur_next       = dur_reg;
        peak_next      = peak_reg;
        prod_next      = prod_reg;
        out_beat_next  = out_beat_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = dur_reg;
        ram_raddr      = pos_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one ring entry a cycle
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = '0;
                if (cnt_reg == CW'(WINDOW_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                // Take a frame, fetch the entry it replaces
                if (in_valid)
                begin
                    dur_next    = (|diff[63:32]) ? 32'hFFFF_FFFF : diff[31:0];
                    frames_next = frames_reg + 1'b1;
                    state_next  = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // Swap the entry into the running sum and the ring
                total_next = total_reg - TOT_W'(ram_rdata) + TOT_W'(dur_reg);
                ram_we     = 1'b1;
                pos_next   = (pos_reg == AW'(WINDOW_LEN - 1)) ? '0 : pos_reg + 1'b1;
                cnt_next   = '0;
                peak_next  = '0;
                prod_next  = '0;
                mstep_next = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                // Advance the peak scan over the ring
                ram_raddr = cnt_reg[AW-1:0];
                if (cnt_reg != CW'(WINDOW_LEN))
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
                if (rd_valid_reg && (ram_rdata > peak_reg))
                begin
                    peak_next = ram_rdata;
                end
                // Accumulate one partial product of the mean
                if (!mul_done)
                begin
                    prod_next  = prod_reg + mul_term;
                    mstep_next = mstep_reg + 1'b1;
                end
                if (scan_done && mul_done)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free, then load it
                if (!out_valid_reg || out_ready)
                begin
                    if (adaptive_reg)
                    begin
                        budget_next = (mean_val > threshold_reg) ?
                                      {1'b0, full_budget_reg[31:1]} : full_budget_reg;
                    end
                    out_beat_next.mean_time   = mean_val;
                    out_beat_next.peak_time   = peak_reg;
                    out_beat_next.budget_now  = budget_next;
                    out_beat_next.frames_seen = frames_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: hdl/swftm_check.sv
module swftm_check
    import swftm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input in_beat_t             in_beat,
    input logic                 out_valid,
    input logic                 out_ready,
    input out_beat_t            out_beat,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [31:0]          cfg_data
);

    // One frame in flight: ready drops after every input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

    // A presented result carries known values
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_beat))
    else $error("result carries unknown bits");

    // A new result appears only while input was held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a frame in work");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_beat)))
    else $error("stalled result changed");

endmodule

bind sliding_window_frame_time_monitor_top swftm_check u_swftm_check (.*);
